>>> src/assert_macros.svh
// Assertion macros used by the verification checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define HNRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define HNRP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> src/hnrp_pkg.sv
// Shared types and constants of the H.264 NAL unit RTP packetizer.
`default_nettype none

package hnrp_pkg;

    localparam int QDEPTH = 4;

    localparam logic [7:0]  FU_A_TYPE = 8'd28;
    localparam logic [7:0]  TYPE_MASK = 8'h1f;
    localparam logic [7:0]  F_BIT     = 8'h80;
    localparam logic [7:0]  NRI_MASK  = 8'h60;

    localparam logic [10:0] MP_RESET  = 11'd1300;
    localparam logic [10:0] MP_MIN    = 11'd4;
    localparam logic [10:0] MP_MAX    = 11'd1400;
    localparam logic [15:0] TS_RESET  = 16'd3600;

    localparam logic CFG_MAX_PAYLOAD  = 1'b0;
    localparam logic CFG_TS_INCREMENT = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COLLECT,
        PH_AWAIT,
        PH_STREAM
    } hnrp_phase_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_SINGLE_MARK,
        MODE_SINGLE_PLAIN,
        MODE_FRAG
    } hnrp_mode_t;

    typedef enum logic [1:0] {
        SUB_IND,
        SUB_FUH,
        SUB_DATA
    } hnrp_sub_t;

    typedef struct packed {
        logic [10:0] max_payload;
        logic [15:0] ts_increment;
    } hnrp_cfg_t;

    // one payload byte, optionally preceded by the two FU-A header bytes
    typedef struct packed {
        logic        hdr;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic        marker;
        logic [15:0] ts;
    } hnrp_entry_t;

endpackage

`default_nettype wire

>>> src/h264_nalu_rtp_packetizer_core.sv
// Top level of the H.264 NAL unit RTP packetizer: config registers and datapath wiring.
// Usage:
//   s_* stream carries one NAL unit buffer byte per word, start code included; the
//   first word has unit_start and the buffer length, the last word has tlast.
//   m_* stream carries RTP payload bytes, FU-A headers included, one per word;
//   tlast closes a packet, tuser gives packet start and the RTP marker, and the
//   upper tdata bits give the timestamp advance on a NAL unit's last word.
//   cfg_* writes max_payload (index 0) and ts_increment (index 1); always ready.
// Timing:
//   With the four-entry queue empty, an accepted payload byte passes the queue and
//   then the output register to m_*; a fragment's first byte follows its two header
//   words, which the queue and backpressure absorb. One byte per cycle is sustained
//   while m_tready is high, outside start code replay. Resolving the start code holds
//   s_tready low while held bytes are replayed: the byte after a three-byte start code,
//   all four with no start code, none after a four-byte one.
// Reset clears all control state and loads max_payload 1300, ts_increment 3600.
// When m_tready is low the output word holds; once the queue fills, s_tready drops.
`default_nettype none

module h264_nalu_rtp_packetizer_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] unit_length
    input  logic        s_tlast,
    input  logic [1:0]  s_tuser,   // [0] unit_start, [1] param_set
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] ts_step
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [0] packet_first, [1] rtp_marker
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import hnrp_pkg::*;

    hnrp_cfg_t   cfg_reg, cfg_next;
    logic        push, q_space, pop, head_valid;
    hnrp_entry_t push_entry, head;
    logic [7:0]  out_byte;
    logic [15:0] out_ts;
    logic        out_first, out_marker;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MAX_PAYLOAD:  cfg_next.max_payload  = cfg_data[10:0];
                CFG_TS_INCREMENT: cfg_next.ts_increment = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_payload  <= MP_RESET;
            cfg_reg.ts_increment <= TS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hnrp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata[7:0]),
        .in_start   (s_tuser[0]),
        .in_end     (s_tlast),
        .in_length  (s_tdata[23:8]),
        .in_param   (s_tuser[1]),
        .push       (push),
        .push_entry (push_entry),
        .q_space    (q_space)
    );

    hnrp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .space      (q_space),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    hnrp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_first  (out_first),
        .out_last   (m_tlast),
        .out_marker (out_marker),
        .out_ts     (out_ts)
    );

    assign m_tdata = {out_ts, out_byte};
    assign m_tuser = {out_marker, out_first};

endmodule

`default_nettype wire

>>> src/hnrp_front.sv
// Front end: start code stripping, packet mode decision and fragment bookkeeping.
`default_nettype none

module hnrp_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hnrp_pkg::hnrp_cfg_t  cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_start,
    input  logic                 in_end,
    input  logic [15:0]          in_length,
    input  logic                 in_param,
    output logic                 push,
    output hnrp_pkg::hnrp_entry_t push_entry,
    input  logic                 q_space
);
    import hnrp_pkg::*;

    logic [7:0]             la_reg [4];
    logic [2:0]             held_reg, held_next;
    logic [7:0]             header_reg, header_next;
    hnrp_mode_t             mode_reg, mode_next;
    logic [LENGTH_BITS-1:0] bl_reg, bl_next;
    logic [10:0]            fill_reg, fill_next;
    hnrp_phase_t            phase_reg, phase_next;
    logic                   ps_reg, ps_next;
    logic [10:0]            mp_reg, mp_next;
    logic                   begun_reg, begun_next;
    logic                   drain_reg, drain_next;
    logic [1:0]             didx_reg, didx_next;
    logic                   endp_reg, endp_next;

    logic                   step_in, step_drain;
    logic                   la_we;
    logic [1:0]             la_widx;
    logic [LENGTH_BITS-1:0] len_w, bl_dec, mp_ext;
    logic [2:0]             held_inc;
    logic [10:0]            mp_clamp;
    logic                   s3, s4;
    logic                   feed_en, awaited;
    logic [7:0]             fb;
    logic [LENGTH_BITS-1:0] fa;
    logic                   fa_zero, fa_fits, endfrag;
    logic [10:0]            fill_inc;

    assign in_ready   = !drain_reg && q_space;
    assign step_in    = in_valid && in_ready;
    assign step_drain = drain_reg && q_space;
    assign len_w      = LENGTH_BITS'(in_length);
    assign bl_dec     = bl_reg - 1'b1;
    assign mp_ext     = {{(LENGTH_BITS-11){1'b0}}, mp_reg};
    assign held_inc   = held_reg + 3'd1;
    assign mp_clamp   = (cfg.max_payload < MP_MIN) ? MP_MIN :
                        ((cfg.max_payload > MP_MAX) ? MP_MAX : cfg.max_payload);
    // start code test; the fourth byte is the one arriving now
    assign s3 = (la_reg[0] == 8'd0) && (la_reg[1] == 8'd0) && (la_reg[2] == 8'd1);
    assign s4 = (la_reg[0] == 8'd0) && (la_reg[1] == 8'd0) && (la_reg[2] == 8'd0) &&
                (in_byte == 8'd1);

    always_comb begin
        held_next   = held_reg;
        header_next = header_reg;
        mode_next   = mode_reg;
        bl_next     = bl_reg;
        fill_next   = fill_reg;
        phase_next  = phase_reg;
        ps_next     = ps_reg;
        mp_next     = mp_reg;
        begun_next  = begun_reg;
        drain_next  = drain_reg;
        didx_next   = didx_reg;
        endp_next   = endp_reg;
        la_we       = 1'b0;
        la_widx     = held_reg[1:0];
        feed_en     = 1'b0;
        awaited     = 1'b0;
        fb          = in_byte;
        fa          = bl_dec;
        fa_zero     = 1'b0;
        fa_fits     = 1'b0;
        endfrag     = 1'b0;
        fill_inc    = '0;
        push        = 1'b0;
        push_entry  = '0;

        if (step_drain) begin
            // replay held bytes that follow the start code, or all of them if there is none
            feed_en   = 1'b1;
            fb        = la_reg[didx_reg];
            fa        = LENGTH_BITS'(2'd3 - didx_reg) + bl_reg;
            didx_next = didx_reg + 2'd1;
            if (didx_reg == 2'd3) begin
                drain_next = 1'b0;
            end
        end else if (step_in) begin
            if (in_start) begin
                mode_next  = MODE_NONE;
                fill_next  = '0;
                begun_next = 1'b0;
                if (len_w < LENGTH_BITS'(4)) begin
                    phase_next = PH_IDLE;
                    bl_next    = '0;
                end else begin
                    phase_next = PH_COLLECT;
                    la_we      = 1'b1;
                    la_widx    = 2'd0;
                    held_next  = 3'd1;
                    bl_next    = len_w - 1'b1;
                    ps_next    = in_param;
                end
            end else begin
                case (phase_reg)
                    PH_COLLECT: begin
                        la_we     = 1'b1;
                        held_next = held_inc;
                        bl_next   = bl_dec;
                        if (held_inc[2]) begin
                            mp_next    = mp_clamp;
                            phase_next = PH_AWAIT;
                            endp_next  = in_end;
                            if (s4 && bl_dec == '0) begin
                                phase_next = PH_IDLE;
                            end else if (s3) begin
                                drain_next = 1'b1;
                                didx_next  = 2'd3;
                            end else if (!s4) begin
                                drain_next = 1'b1;
                                didx_next  = 2'd0;
                            end
                        end
                    end
                    PH_AWAIT, PH_STREAM: begin
                        if (bl_reg != '0) begin
                            bl_next = bl_dec;
                            feed_en = 1'b1;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (feed_en) begin
            fa_zero = (fa == '0);
            fa_fits = (fa < mp_ext);
            if (phase_next == PH_AWAIT) begin
                // NAL header byte: pick the packet mode
                awaited     = 1'b1;
                header_next = fb;
                mode_next   = ps_reg ? MODE_SINGLE_PLAIN :
                              (fa_fits ? MODE_SINGLE_MARK : MODE_FRAG);
                phase_next  = PH_STREAM;
                fill_next   = '0;
                begun_next  = 1'b0;
            end
            if (awaited && mode_next == MODE_FRAG) begin
                push = 1'b0;
            end else if (mode_next == MODE_FRAG) begin
                push              = 1'b1;
                push_entry.hdr    = (fill_next == '0);
                push_entry.fu_ind = (header_next & (F_BIT | NRI_MASK)) | FU_A_TYPE;
                push_entry.fu_hdr = {!begun_next, fa_fits, 6'd0} | (header_next & TYPE_MASK);
                if (fill_next == '0) begin
                    begun_next = 1'b1;
                end
                fill_inc          = fill_next + 11'd1;
                endfrag           = fa_zero || (fill_inc >= mp_reg);
                push_entry.data   = fb;
                push_entry.first  = 1'b0;
                push_entry.last   = endfrag;
                push_entry.marker = fa_zero;
                push_entry.ts     = fa_zero ? cfg.ts_increment : 16'd0;
                fill_next         = endfrag ? 11'd0 : fill_inc;
            end else begin
                push              = 1'b1;
                push_entry.hdr    = 1'b0;
                push_entry.data   = fb;
                push_entry.first  = (fill_next == '0);
                push_entry.last   = fa_zero;
                push_entry.marker = fa_zero && (mode_next == MODE_SINGLE_MARK);
                push_entry.ts     = fa_zero ? cfg.ts_increment : 16'd0;
                fill_next         = 11'd1;
            end
            if (fa_zero) begin
                phase_next = PH_IDLE;
            end
        end

        if (step_drain && didx_reg == 2'd3 && endp_reg) begin
            phase_next = PH_IDLE;
        end
        if (step_in && in_end && !drain_next) begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg   <= '0;
            header_reg <= '0;
            mode_reg   <= MODE_NONE;
            bl_reg     <= '0;
            fill_reg   <= '0;
            phase_reg  <= PH_IDLE;
            ps_reg     <= 1'b0;
            mp_reg     <= MP_RESET;
            begun_reg  <= 1'b0;
            drain_reg  <= 1'b0;
            didx_reg   <= '0;
            endp_reg   <= 1'b0;
        end else begin
            held_reg   <= held_next;
            header_reg <= header_next;
            mode_reg   <= mode_next;
            bl_reg     <= bl_next;
            fill_reg   <= fill_next;
            phase_reg  <= phase_next;
            ps_reg     <= ps_next;
            mp_reg     <= mp_next;
            begun_reg  <= begun_next;
            drain_reg  <= drain_next;
            didx_reg   <= didx_next;
            endp_reg   <= endp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (la_we) begin
            la_reg[la_widx] <= in_byte;
        end
    end

endmodule

`default_nettype wire

>>> src/hnrp_queue.sv
// Short entry queue between the front end and the output sequencer.
`default_nettype none

module hnrp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  hnrp_pkg::hnrp_entry_t push_entry,
    output logic                  space,
    input  logic                  pop,
    output logic                  head_valid,
    output hnrp_pkg::hnrp_entry_t head
);
    import hnrp_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    hnrp_entry_t   mem_reg [QDEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign space      = (count_reg != (PW+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_reg];
    assign do_push    = push && space;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_next    = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = do_pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> src/hnrp_back.sv
// Output sequencer: expands queue entries into words and holds the output register.
`default_nettype none

module hnrp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  hnrp_pkg::hnrp_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_first,
    output logic                  out_last,
    output logic                  out_marker,
    output logic [15:0]           out_ts
);
    import hnrp_pkg::*;

    hnrp_sub_t   sub_reg, sub_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg;
    logic        first_reg, last_reg, marker_reg;
    logic [15:0] ts_reg;

    logic        load, final_word;
    logic [7:0]  w_byte;
    logic        w_first, w_last, w_marker;
    logic [15:0] w_ts;

    assign load = head_valid && (!valid_reg || out_ready);

    always_comb begin
        w_byte     = head.data;
        w_first    = head.first;
        w_last     = head.last;
        w_marker   = head.marker;
        w_ts       = head.ts;
        final_word = 1'b1;
        case (sub_reg)
            SUB_IND: begin
                if (head.hdr) begin
                    w_byte     = head.fu_ind;
                    w_first    = 1'b1;
                    w_last     = 1'b0;
                    w_marker   = 1'b0;
                    w_ts       = '0;
                    final_word = 1'b0;
                end
            end
            SUB_FUH: begin
                w_byte     = head.fu_hdr;
                w_first    = 1'b0;
                w_last     = 1'b0;
                w_marker   = 1'b0;
                w_ts       = '0;
                final_word = 1'b0;
            end
            SUB_DATA: final_word = 1'b1;
            default:  final_word = 1'b1;
        endcase

        sub_next = sub_reg;
        if (load) begin
            if (final_word) begin
                sub_next = SUB_IND;
            end else if (sub_reg == SUB_IND) begin
                sub_next = SUB_FUH;
            end else begin
                sub_next = SUB_DATA;
            end
        end
        pop        = load && final_word;
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= SUB_IND;
            valid_reg <= 1'b0;
        end else begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= w_byte;
            first_reg  <= w_first;
            last_reg   <= w_last;
            marker_reg <= w_marker;
            ts_reg     <= w_ts;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign out_first  = first_reg;
    assign out_last   = last_reg;
    assign out_marker = marker_reg;
    assign out_ts     = ts_reg;

endmodule

`default_nettype wire

>>> src/hnrp_checker.sv
// Port-level checker for the packetizer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module hnrp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

`HNRP_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "output valid after reset")
`HNRP_ASSERT(a_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "output word dropped")
`HNRP_ASSERT(a_marker_last, m_tvalid && m_tuser[1] |-> m_tlast, "marker off packet end")
`HNRP_ASSERT(a_ts_last, m_tvalid && !m_tlast |-> m_tdata[23:8] == 16'd0, "ts step mid packet")

endmodule

bind h264_nalu_rtp_packetizer_core hnrp_checker u_checker (.*);

`default_nettype wire

>>> sim/tb_h264_nalu_rtp_packetizer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the NAL unit RTP packetizer: directed units, random traffic, predictor.

module tb_h264_nalu_rtp_packetizer_core;
    import hnrp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        unit_start;
        logic        unit_end;
        logic [15:0] unit_length;
        logic        param_set;
    } nal_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        packet_first;
        logic        packet_last;
        logic        rtp_marker;
        logic [15:0] ts_step;
    } payload_word_t;

    class rtp_payload_scoreboard;
        logic [10:0]   max_payload;
        logic [15:0]   ts_increment;
        logic [7:0]    held_bytes[4];
        logic [2:0]    held_count;
        logic [7:0]    nal_header;
        hnrp_mode_t    mode;
        logic [15:0]   bytes_left;
        logic [10:0]   frag_fill;
        hnrp_phase_t   phase;
        logic          ps_flag;
        logic [10:0]   limit;
        logic          frag_started;
        payload_word_t expected_words[$];
        int            errors;

        function new();
            max_payload = MP_RESET;
            ts_increment = TS_RESET;
            for (int i = 0; i < 4; i++) held_bytes[i] = 8'h00;
            held_count = 3'd0;
            nal_header = 8'h00;
            mode = MODE_NONE;
            bytes_left = 16'd0;
            frag_fill = 11'd0;
            phase = PH_IDLE;
            ps_flag = 1'b0;
            limit = MP_RESET;
            frag_started = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [15:0] val);
            if (idx == CFG_MAX_PAYLOAD) max_payload = val[10:0];
            else ts_increment = val;
        endfunction

        function void push_word(logic [7:0] b, logic first, logic last, logic marker,
                                logic [15:0] ts);
            payload_word_t w;
            w.out_byte = b;
            w.packet_first = first;
            w.packet_last = last;
            w.rtp_marker = marker;
            w.ts_step = ts;
            expected_words.push_back(w);
        endfunction

        // one byte of the stripped unit; remaining = bytes still to follow
        function void emit_byte(logic [7:0] b, int unsigned remaining);
            logic endfrag;
            logic s_bit;
            logic e_bit;
            if (phase == PH_AWAIT) begin
                nal_header = b;
                if (ps_flag) mode = MODE_SINGLE_PLAIN;
                else if (remaining + 1 <= limit) mode = MODE_SINGLE_MARK;
                else mode = MODE_FRAG;
                phase = PH_STREAM;
                frag_fill = 11'd0;
                frag_started = 1'b0;
                if (mode == MODE_FRAG) return;
            end
            if (mode == MODE_FRAG) begin
                if (frag_fill == 11'd0) begin
                    s_bit = !frag_started;
                    e_bit = (remaining + 1 <= limit);
                    push_word((nal_header & (F_BIT | NRI_MASK)) | FU_A_TYPE,
                              1'b1, 1'b0, 1'b0, 16'd0);
                    push_word({s_bit, e_bit, 1'b0, nal_header[4:0]}, 1'b0, 1'b0, 1'b0, 16'd0);
                    frag_started = 1'b1;
                end
                frag_fill = frag_fill + 11'd1;
                endfrag = (remaining == 0) || (frag_fill >= limit);
                push_word(b, 1'b0, endfrag, remaining == 0,
                          remaining == 0 ? ts_increment : 16'd0);
                if (endfrag) frag_fill = 11'd0;
            end else begin
                push_word(b, frag_fill == 11'd0, remaining == 0,
                          remaining == 0 && mode == MODE_SINGLE_MARK,
                          remaining == 0 ? ts_increment : 16'd0);
                frag_fill = 11'd1;
            end
            if (remaining == 0) phase = PH_IDLE;
        endfunction

        function void resolve_start_code();
            int skip;
            skip = 0;
            limit = max_payload < MP_MIN ? MP_MIN :
                    (max_payload > MP_MAX ? MP_MAX : max_payload);
            if (held_bytes[0] == 8'h00 && held_bytes[1] == 8'h00 && held_bytes[2] == 8'h01)
                skip = 3;
            else if (held_bytes[0] == 8'h00 && held_bytes[1] == 8'h00 &&
                     held_bytes[2] == 8'h00 && held_bytes[3] == 8'h01)
                skip = 4;
            phase = PH_AWAIT;
            if (skip == 4 && bytes_left == 16'd0) begin
                phase = PH_IDLE;
                return;
            end
            for (int i = skip; i < 4; i++)
                emit_byte(held_bytes[i], 32'(3 - i) + 32'(bytes_left));
        endfunction

        function void note_nal_word(nal_word_t w);
            if (w.unit_start) begin
                mode = MODE_NONE;
                frag_fill = 11'd0;
                frag_started = 1'b0;
                if (w.unit_length < 16'd4) begin
                    phase = PH_IDLE;
                    bytes_left = 16'd0;
                end else begin
                    phase = PH_COLLECT;
                    held_bytes[0] = w.data_byte;
                    held_count = 3'd1;
                    bytes_left = w.unit_length - 16'd1;
                    ps_flag = w.param_set;
                end
            end else if (phase == PH_COLLECT) begin
                held_bytes[held_count[1:0]] = w.data_byte;
                held_count = held_count + 3'd1;
                bytes_left = bytes_left - 16'd1;
                if (held_count >= 3'd4) resolve_start_code();
            end else if (phase == PH_AWAIT || phase == PH_STREAM) begin
                if (bytes_left > 16'd0) begin
                    bytes_left = bytes_left - 16'd1;
                    emit_byte(w.data_byte, 32'(bytes_left));
                end else begin
                    phase = PH_IDLE;
                end
            end
            if (w.unit_end) phase = PH_IDLE;
        endfunction

        function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
            if (exp_val !== act_val) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val,
                         act_val);
            end
        endfunction

        function void check_payload_word(payload_word_t got);
            payload_word_t exp_w;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, got byte %02h", $time,
                         got.out_byte);
                return;
            end
            exp_w = expected_words.pop_front();
            compare_field("out_byte", 16'(exp_w.out_byte), 16'(got.out_byte));
            compare_field("packet_first", 16'(exp_w.packet_first), 16'(got.packet_first));
            compare_field("packet_last", 16'(exp_w.packet_last), 16'(got.packet_last));
            compare_field("rtp_marker", 16'(exp_w.rtp_marker), 16'(got.rtp_marker));
            compare_field("ts_step", exp_w.ts_step, got.ts_step);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    rtp_payload_scoreboard sb = new();

    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         words_sent = 0;
    int         cycle_count = 0;
    logic       hold_request = 1'b0;
    logic       hold_taken = 1'b0;
    int         hold_left = 0;
    logic [7:0] nal_buf[$];

    h264_nalu_rtp_packetizer_core dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_request != hold_taken) begin
            hold_taken = hold_request;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_payload_word({m_tdata[7:0], m_tuser[0], m_tlast, m_tuser[1],
                                   m_tdata[23:8]});
    end

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(logic [7:0] b, logic st, logic en, logic [15:0] len, logic ps);
        nal_word_t w;
        w.data_byte = b;
        w.unit_start = st;
        w.unit_end = en;
        w.unit_length = len;
        w.param_set = ps;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {len, b};
        s_tlast <= en;
        s_tuser <= {ps, st};
        do @(posedge aclk); while (!s_tready);
        sb.note_nal_word(w);
        words_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic build_nal(int sc, logic [7:0] hdr, int body);
        nal_buf.delete();
        if (sc == 3) begin
            nal_buf.push_back(8'h00);
            nal_buf.push_back(8'h00);
            nal_buf.push_back(8'h01);
        end else if (sc == 4) begin
            nal_buf.push_back(8'h00);
            nal_buf.push_back(8'h00);
            nal_buf.push_back(8'h00);
            nal_buf.push_back(8'h01);
        end
        nal_buf.push_back(hdr);
        repeat (body) nal_buf.push_back(8'($urandom_range(255)));
    endtask

    // len is what the first word claims; only the first nsend bytes go out
    task automatic send_buf(int len, logic ps, int nsend, logic end_last);
        for (int i = 0; i < nsend; i++)
            send_word(nal_buf[i], i == 0, end_last && i == nsend - 1,
                      i == 0 ? 16'(len) : 16'($urandom_range(65535)),
                      i == 0 ? ps : 1'($urandom_range(1)));
    endtask

    task automatic send_whole(int sc, logic [7:0] hdr, int body, logic ps);
        build_nal(sc, hdr, body);
        send_buf(nal_buf.size(), ps, nal_buf.size(), 1'b1);
    endtask

    task automatic rand_unit(int mp_eff);
        int r;
        int sc;
        int body;
        int bmax;
        int n;
        logic [7:0] h;
        r = $urandom_range(99);
        case ($urandom_range(2))
            0: sc = 0;
            1: sc = 3;
            default: sc = 4;
        endcase
        h = 8'($urandom_range(255));
        h[7] = ($urandom_range(9) == 0);
        if (r < 78) begin
            bmax = mp_eff <= 16 ? 3 * mp_eff + 2 : 30;
            if (mp_eff <= 16 && $urandom_range(3) == 0)
                body = mp_eff - 2 + $urandom_range(4);
            else
                body = $urandom_range(bmax);
            send_whole(sc, h, body, $urandom_range(9) == 0);
        end else if (r < 84) begin
            repeat ($urandom_range(1, 3))
                send_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                          16'($urandom_range(65535)), 1'($urandom_range(1)));
        end else if (r < 88) begin
            build_nal(0, h, 3);
            send_buf($urandom_range(3), 1'b0, $urandom_range(1, 4), 1'($urandom_range(1)));
        end else if (r < 94) begin
            // abandoned: early end or cut off by the next start
            build_nal(sc, h, $urandom_range(2, 20));
            n = $urandom_range(1, nal_buf.size() - 1);
            send_buf($urandom_range(nal_buf.size() + 1, 65535), 1'($urandom_range(1)), n,
                     1'($urandom_range(1)));
        end else begin
            build_nal(sc, h, $urandom_range(2, 10));
            send_buf(nal_buf.size() - $urandom_range(1, 2), 1'b0, nal_buf.size(), 1'b1);
        end
    endtask

    task automatic run_phase(int mp, int ts, int s_idle, int r_stall, int nbytes,
                             int big_body, logic pressure);
        int first_word;
        int mp_eff;
        logic paused;
        write_reg(CFG_MAX_PAYLOAD, 16'(mp));
        write_reg(CFG_TS_INCREMENT, 16'(ts));
        mp_eff = mp < 4 ? 4 : (mp > 1400 ? 1400 : mp);
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        if (pressure) hold_request = ~hold_request;
        first_word = words_sent;
        paused = 1'b0;
        if (big_body > 0) begin
            send_whole(4, 8'h65, big_body, 1'b0);
            send_whole(4, 8'h41, big_body - 3, 1'b0);
        end
        while (words_sent - first_word < nbytes) begin
            rand_unit(mp_eff);
            if (pressure && !paused && words_sent - first_word >= nbytes / 2) begin
                stop_sending();
                wait_drained();
                paused = 1'b1;
            end
        end
        send_whole(3, 8'h41, 2, 1'b0);
        stop_sending();
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 24'd0;
        s_tlast = 1'b0;
        s_tuser = 2'd0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAX_PAYLOAD;
        cfg_data = 16'd0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        write_reg(CFG_MAX_PAYLOAD, 16'd4);
        write_reg(CFG_TS_INCREMENT, 16'hffff);
        // bytes while idle
        send_word(8'h00, 1'b0, 1'b0, 16'hffff, 1'b1);
        send_word(8'hff, 1'b0, 1'b1, 16'h0000, 1'b0);
        // buffers too short to keep
        build_nal(0, 8'hff, 3);
        send_buf(0, 1'b0, 2, 1'b0);
        send_buf(3, 1'b1, 3, 1'b1);
        // start code only
        nal_buf = '{8'h00, 8'h00, 8'h00, 8'h01};
        send_buf(4, 1'b0, 4, 1'b1);
        send_whole(3, 8'h65, 2, 1'b0);
        send_whole(4, 8'h41, 3, 1'b0);
        send_whole(4, 8'h65, 4, 1'b0);
        send_whole(3, 8'he5, 10, 1'b0);
        send_whole(0, 8'h61, 9, 1'b0);
        send_whole(4, 8'h67, 9, 1'b1);
        send_whole(3, 8'h68, 1, 1'b1);
        send_whole(0, 8'h00, 5, 1'b0);
        send_whole(0, 8'hff, 6, 1'b0);
        // new start while the unit is still running
        build_nal(4, 8'h65, 12);
        send_buf(nal_buf.size(), 1'b0, 9, 1'b0);
        // end flagged before the length is used up
        build_nal(3, 8'h41, 10);
        send_buf(nal_buf.size(), 1'b0, 8, 1'b1);
        build_nal(4, 8'h65, 5);
        send_buf(65535, 1'b0, nal_buf.size(), 1'b1);
        // bytes beyond the given length
        build_nal(4, 8'h41, 2);
        send_buf(5, 1'b0, nal_buf.size(), 1'b1);
        send_whole(3, 8'h41, 2, 1'b0);
        stop_sending();
        wait_drained();

        run_phase(1400, 0, 0, 0, 20, 0, 1'b0);
        run_phase(0, $urandom_range(65535), 86, 0, 15, 0, 1'b0);
        run_phase(7, 1, 0, 86, 20, 0, 1'b0);
        run_phase(2047, $urandom_range(65535), 21, 21, 20, 0, 1'b0);
        run_phase(5, $urandom_range(65535), 0, 0, 30, 0, 1'b1);
        run_phase(16, TS_RESET, 21, 21, 20, 0, 1'b0);

        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/hnrp_pkg.sv
src/hnrp_front.sv
src/hnrp_queue.sv
src/hnrp_back.sv
src/h264_nalu_rtp_packetizer_core.sv
src/hnrp_checker.sv
sim/tb_h264_nalu_rtp_packetizer_core.sv
